// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
// Every macro samples on the rising edge of clock and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`define ASSERT_IMPLIES(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

`define ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)

`define ASSERT_IMPLIES(label, cond, expr, msg)

`define ASSERT_NEXT(label, cond, expr, msg)

`endif

`endif

// ===== src/ird_pkg.sv =====
`timescale 1ns / 1ps

package ird_pkg;

   localparam int MAX_RADIX      = 64;
   localparam int IDX_W          = $clog2(MAX_RADIX);
   localparam int RADIX_W        = $clog2(MAX_RADIX + 1);
   localparam int TRIAL_W        = IDX_W + 1;
   localparam int VALUE_W        = 32;
   localparam int SYM_W          = 8;
   localparam int SYM_COUNT      = 1 << SYM_W;
   localparam int DIGITS_MAX     = VALUE_W;
   localparam int DCNT_W         = $clog2(DIGITS_MAX + 1);
   localparam int DPTR_W         = $clog2(DIGITS_MAX);
   localparam int BITS_PER_CYCLE = 4;
   localparam int DIV_STEPS      = VALUE_W / BITS_PER_CYCLE;
   localparam int STEP_W         = $clog2(DIV_STEPS);

   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_APPEND  = 2'd1;
   localparam logic [1:0] OP_CONVERT = 2'd2;

   localparam logic [SYM_W-1:0] SYM_SPACE = 8'h20;
   localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] SYM_NONE  = 8'h00;

   typedef struct packed {
      logic clear;
      logic append;
      logic load;
      logic div_step;
      logic push;
      logic read;
      logic set_sign;
      logic set_zero;
   } cmd_type;

   typedef struct packed {
      logic alpha_ok;
      logic value_neg;
      logic div_last;
      logic quot_zero;
      logic last_digit;
   } status_type;

endpackage

// ===== src/ird_dpath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ird_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  ird_pkg::cmd_type              cmd,
   input  logic [ird_pkg::SYM_W-1:0]     req_symbol,
   input  logic signed [ird_pkg::VALUE_W-1:0] req_value,
   output ird_pkg::status_type           status,
   output logic [ird_pkg::SYM_W-1:0]     rsp_character
);
   import ird_pkg::*;

   logic [SYM_W-1:0]     digit_table [MAX_RADIX];
   logic [RADIX_W-1:0]   radix_count_ff;
   logic [SYM_COUNT-1:0] seen_ff;
   logic                 bad_ff;

   logic [VALUE_W-1:0]   quot_ff;
   logic [IDX_W-1:0]     rem_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [IDX_W-1:0]     stack_ff [DIGITS_MAX];
   logic [DCNT_W-1:0]    depth_ff;
   logic [SYM_W-1:0]     char_ff;

   logic [VALUE_W-1:0]   quot_in;
   logic [IDX_W-1:0]     rem_in;
   logic [VALUE_W-1:0]   magnitude;
   logic                 reject;
   logic                 store_symbol;
   logic [DPTR_W-1:0]    top_ptr;

   assign reject = (req_symbol == SYM_SPACE) || (req_symbol == SYM_PLUS) ||
                   (req_symbol == SYM_MINUS) || seen_ff[req_symbol] ||
                   (radix_count_ff >= RADIX_W'(MAX_RADIX));
   assign store_symbol = cmd.append && !bad_ff && !reject;

   assign magnitude = req_value[VALUE_W-1] ? (~req_value) + VALUE_W'(1) : req_value;
   assign top_ptr   = DPTR_W'(depth_ff - DCNT_W'(1));

   always_comb begin
      logic [TRIAL_W-1:0] trial;
      logic [IDX_W-1:0]   rem_work;
      logic [VALUE_W-1:0] quot_work;
      rem_work  = rem_ff;
      quot_work = quot_ff;
      for (int i = 0; i < BITS_PER_CYCLE; i++) begin
         trial     = {rem_work, quot_work[VALUE_W-1]};
         quot_work = {quot_work[VALUE_W-2:0], 1'b0};
         if (trial >= TRIAL_W'(radix_count_ff)) begin
            rem_work     = IDX_W'(trial - TRIAL_W'(radix_count_ff));
            quot_work[0] = 1'b1;
         end else begin
            rem_work = trial[IDX_W-1:0];
         end
      end
      rem_in  = rem_work;
      quot_in = quot_work;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_count_ff <= '0;
         seen_ff        <= '0;
         bad_ff         <= 1'b0;
      end else if (cmd.clear) begin
         radix_count_ff <= '0;
         seen_ff        <= '0;
         bad_ff         <= 1'b0;
      end else if (cmd.append && !bad_ff) begin
         if (reject) begin
            bad_ff <= 1'b1;
         end else begin
            seen_ff[req_symbol] <= 1'b1;
            radix_count_ff      <= radix_count_ff + RADIX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_symbol) begin
         digit_table[radix_count_ff[IDX_W-1:0]] <= req_symbol;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         step_ff  <= '0;
      end else if (cmd.load) begin
         depth_ff <= '0;
         step_ff  <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + STEP_W'(1);
      end else if (cmd.push) begin
         depth_ff <= depth_ff + DCNT_W'(1);
         step_ff  <= '0;
      end else if (cmd.read) begin
         depth_ff <= depth_ff - DCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quot_ff <= magnitude;
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end else if (cmd.push) begin
         stack_ff[depth_ff[DPTR_W-1:0]] <= rem_ff;
         rem_ff                         <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_zero) begin
         char_ff <= SYM_NONE;
      end else if (cmd.set_sign) begin
         char_ff <= SYM_MINUS;
      end else if (cmd.read) begin
         char_ff <= digit_table[stack_ff[top_ptr]];
      end
   end

   assign rsp_character     = char_ff;
   assign status.alpha_ok   = !bad_ff && (radix_count_ff >= RADIX_W'(2));
   assign status.value_neg  = req_value[VALUE_W-1];
   assign status.div_last   = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign status.quot_zero  = (quot_ff == '0);
   assign status.last_digit = (depth_ff == DCNT_W'(1));

   `ASSERT_ALWAYS(a_radix_bound, radix_count_ff <= RADIX_W'(MAX_RADIX), "radix count overflow")
   `ASSERT_IMPLIES(a_push_room, cmd.push, depth_ff < DCNT_W'(DIGITS_MAX), "digit stack overflow")
   `ASSERT_IMPLIES(a_read_data, cmd.read, depth_ff != '0, "read from empty digit stack")

endmodule

// ===== src/ird_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ird_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_opcode,
   output logic                req_stall,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic                rsp_is_last,
   output logic                rsp_alphabet_error,
   input  ird_pkg::status_type status,
   output ird_pkg::cmd_type    cmd
);
   import ird_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIGN,
      ST_DIVIDE,
      ST_PUSH,
      ST_READ,
      ST_SEND,
      ST_ERROR
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_is_last_ff;
   logic      rsp_error_ff;
   logic      accept;
   logic      convert;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign convert   = accept && (req_opcode == OP_CONVERT);

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_CLEAR:  cmd.clear  = 1'b1;
                  OP_APPEND: cmd.append = 1'b1;
                  OP_CONVERT: begin
                     if (!status.alpha_ok) begin
                        cmd.set_zero = 1'b1;
                     end else begin
                        cmd.load     = 1'b1;
                        cmd.set_sign = status.value_neg;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_PUSH:   cmd.push     = 1'b1;
         ST_READ:   cmd.read     = 1'b1;
         ST_SIGN, ST_SEND, ST_ERROR: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         rsp_is_last_ff <= 1'b0;
         rsp_error_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (convert) begin
                  if (!status.alpha_ok) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_is_last_ff <= 1'b1;
                     rsp_error_ff   <= 1'b1;
                     state_ff       <= ST_ERROR;
                  end else if (status.value_neg) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_is_last_ff <= 1'b0;
                     rsp_error_ff   <= 1'b0;
                     state_ff       <= ST_SIGN;
                  end else begin
                     state_ff <= ST_DIVIDE;
                  end
               end
            end
            ST_SIGN: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_DIVIDE;
               end
            end
            ST_ERROR: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  rsp_error_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_DIVIDE: begin
               if (status.div_last) begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               state_ff <= status.quot_zero ? ST_READ : ST_DIVIDE;
            end
            ST_READ: begin
               rsp_valid_ff   <= 1'b1;
               rsp_is_last_ff <= status.last_digit;
               rsp_error_ff   <= 1'b0;
               state_ff       <= ST_SEND;
            end
            ST_SEND: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= rsp_is_last_ff ? ST_IDLE : ST_READ;
               end
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_last        = rsp_is_last_ff;
   assign rsp_alphabet_error = rsp_error_ff;

   `ASSERT_IMPLIES(a_err_last, rsp_valid_ff && rsp_error_ff, rsp_is_last_ff, "error must be last")
   `ASSERT_IMPLIES(a_div_quiet, state_ff == ST_DIVIDE, !rsp_valid_ff, "output busy in divide")
   `ASSERT_NEXT(a_bad_reply, convert && !status.alpha_ok, rsp_valid_ff && rsp_error_ff, "no error reply")

endmodule

// ===== src/integer_to_radix_digits.sv =====
`timescale 1ns / 1ps
// Clear and append requests take effect when accepted; a convert request is accepted,
// then each digit passes through the shared divider (4 quotient bits a cycle, plus one push),
// then each emitted character takes a digit table read, then a send; a minus sign goes first.
// A bad alphabet answers in the cycle after acceptance; the next request waits for delivery.
// Synchronous active-high reset empties the alphabet and idles the controller.

module integer_to_radix_digits (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_opcode,
   input  logic [ird_pkg::SYM_W-1:0]           req_symbol,
   input  logic signed [ird_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ird_pkg::SYM_W-1:0]           rsp_character,
   output logic                                rsp_is_last,
   output logic                                rsp_alphabet_error
);
   import ird_pkg::*;

   cmd_type    cmd;
   status_type status;

   ird_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_opcode         (req_opcode),
      .req_stall          (req_stall),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_is_last        (rsp_is_last),
      .rsp_alphabet_error (rsp_alphabet_error),
      .status             (status),
      .cmd                (cmd)
   );

   ird_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_symbol    (req_symbol),
      .req_value     (req_value),
      .status        (status),
      .rsp_character (rsp_character)
   );

endmodule
